### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the vertex dedup facet table.
// Bodies are empty when SYNTHESIS is defined; needs i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset only
`define MVD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define MVD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MVD_ASSERT(lbl, prop, msg)
`define MVD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/core/mvd_pkg.sv
// Shared types, sizes and codes of the vertex dedup facet table.
// No dependencies; used by mvd_corner_match and mesh_vertex_dedup_facet_table.
package mvd_pkg;

    // Table sizes
    localparam int MAX_POINTS = 1024;
    localparam int MAX_FACETS = 1024;

    localparam int PNT_IDX_W = $clog2(MAX_POINTS);
    localparam int FCT_IDX_W = $clog2(MAX_FACETS);
    localparam int PNT_CNT_W = $clog2(MAX_POINTS + 1);
    localparam int FCT_CNT_W = $clog2(MAX_FACETS + 1);
    // Scan pointer covers both tables
    localparam int SCAN_W    = (PNT_CNT_W > FCT_CNT_W) ? PNT_CNT_W : FCT_CNT_W;
    localparam int FACET_W   = 3 * PNT_IDX_W;

    // Stream payload widths
    localparam int COORD_W    = 64;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_IDX_W  = 10;
    localparam int OUT_CNT_W  = 11;
    localparam int IN_DATA_W  = 9 * COORD_W;
    localparam int IN_USER_W  = CMD_W;
    localparam int OUT_RAW_W  = STATUS_W + 3 * OUT_IDX_W + 2 * OUT_CNT_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // One point, x in the low bits
    typedef struct packed {
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_point;

    // Priority match of one stored point against the three corners
    typedef struct packed {
        logic third;
        logic second;
        logic first;
    } t_match;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NO_POINTS = 2'd2,
        STS_NO_FACET  = 2'd3
    } t_status;

endpackage

### rtl/core/mvd_corner_match.sv
// Shared point comparator: one stored point against the three corners.
// Depends on mvd_pkg.
module mvd_corner_match (
    input  mvd_pkg::t_point i_stored,
    input  mvd_pkg::t_point i_corner [3],
    output mvd_pkg::t_match o_match
);
    import mvd_pkg::*;

    logic w_eq1;
    logic w_eq2;
    logic w_eq3;

    // Bitwise equality, so +0 and -0 differ
    assign w_eq1 = (i_stored == i_corner[0]);
    assign w_eq2 = (i_stored == i_corner[1]);
    assign w_eq3 = (i_stored == i_corner[2]);

    // Corner one first, then two, then three
    always_comb begin
        o_match.first  = w_eq1;
        o_match.second = !w_eq1 && w_eq2;
        o_match.third  = !w_eq1 && !w_eq2 && w_eq3;
    end

endmodule

### rtl/core/mesh_vertex_dedup_facet_table.sv
// Top level of the vertex dedup facet table: sequencer, point and facet memories.
// Depends on mvd_pkg, mvd_corner_match and assert_macros.svh.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser: command; tdata: 3 corners x,y,z
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: status, 3 indices, counts
//
// Insert scans the points, then appends new corners and the facet; remove scans the
// points, then the facets. A full table or a missing corner ends after the point scan;
// clear and the unused command go straight to the result. The point scan is set by the
// single read port of the point memory (one point per cycle); remove then streams the
// facet memory once, finding the facet and shifting later ones down in the same pass.
// Reset (synchronous, active low) empties both tables; memory contents are kept.
// The input is not ready from acceptance until the result transfer completes.
`include "assert_macros.svh"

module mesh_vertex_dedup_facet_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // first_x, first_y, first_z, second_x..z, third_x..z (64 bits each)
    input  logic [mvd_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // command
    input  logic [mvd_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status, first_index, second_index, third_index, facets_held, points_held, zero pad
    output logic [mvd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import mvd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_PSCAN   = 7'b0000010,
        S_DECIDE  = 7'b0000100,
        S_APPEND  = 7'b0001000,
        S_FAPPEND = 7'b0010000,
        S_FSCAN   = 7'b0100000,
        S_RESULT  = 7'b1000000
    } t_state;

    // Control
    t_state                 r_state;
    logic [PNT_CNT_W-1:0]   r_pcount;
    logic [FCT_CNT_W-1:0]   r_fcount;
    logic [SCAN_W-1:0]      r_ptr;
    logic                   r_rv;
    logic                   r_found;

    // Item payload
    logic [CMD_W-1:0]       r_cmd;
    t_point                 r_corner [3];
    logic [2:0]             r_hit;
    logic [PNT_IDX_W-1:0]   r_idx [3];
    logic [1:0]             r_k;
    logic [SCAN_W-1:0]      r_ridx;
    t_status                r_status;
    logic                   r_report;

    // Memories
    t_point                 r_pt_mem [MAX_POINTS];
    logic [FACET_W-1:0]     r_fc_mem [MAX_FACETS];
    t_point                 r_pt_rd;
    logic [FACET_W-1:0]     r_fc_rd;

    logic                   w_accept;
    logic                   w_rd_issue;
    logic                   w_pt_we;
    logic                   w_fc_we;
    logic [FCT_IDX_W-1:0]   w_fc_waddr;
    logic [FACET_W-1:0]     w_fc_wdata;
    logic [SCAN_W-1:0]      w_prev;
    logic [1:0]             w_missing;
    logic                   w_full;
    logic                   w_tri_match;
    logic [PNT_IDX_W-1:0]   w_s0;
    logic [PNT_IDX_W-1:0]   w_s1;
    logic [PNT_IDX_W-1:0]   w_s2;
    t_match                 w_match;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_RESULT);

    // Shared comparator for the point scan
    mvd_corner_match u_match (
        .i_stored (r_pt_rd),
        .i_corner (r_corner),
        .o_match  (w_match)
    );

    // Read issue, write ports, full check and facet compare
    always_comb begin
        w_rd_issue = ((r_state == S_PSCAN) && (r_ptr != SCAN_W'(r_pcount))) ||
                     ((r_state == S_FSCAN) && (r_ptr != SCAN_W'(r_fcount)));
        w_pt_we    = (r_state == S_APPEND) && !r_hit[r_k];
        w_prev     = r_ridx - SCAN_W'(1);
        w_fc_we    = (r_state == S_FAPPEND) || ((r_state == S_FSCAN) && r_rv && r_found);
        w_fc_waddr = (r_state == S_FAPPEND) ? r_fcount[FCT_IDX_W-1:0]
                                            : w_prev[FCT_IDX_W-1:0];
        w_fc_wdata = (r_state == S_FAPPEND) ? {r_idx[2], r_idx[1], r_idx[0]} : r_fc_rd;
        w_missing  = 2'(!r_hit[0]) + 2'(!r_hit[1]) + 2'(!r_hit[2]);
        w_full     = (r_fcount >= FCT_CNT_W'(MAX_FACETS)) ||
                     ((PNT_CNT_W + 1)'(r_pcount) + (PNT_CNT_W + 1)'(w_missing) >
                      (PNT_CNT_W + 1)'(MAX_POINTS));
        w_s0       = r_fc_rd[PNT_IDX_W-1:0];
        w_s1       = r_fc_rd[2*PNT_IDX_W-1:PNT_IDX_W];
        w_s2       = r_fc_rd[3*PNT_IDX_W-1:2*PNT_IDX_W];
        w_tri_match = (w_s0 == r_idx[0] && w_s1 == r_idx[1] && w_s2 == r_idx[2]) ||
                      (w_s0 == r_idx[1] && w_s1 == r_idx[2] && w_s2 == r_idx[0]) ||
                      (w_s0 == r_idx[2] && w_s1 == r_idx[0] && w_s2 == r_idx[1]);
    end

    // Point memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt_mem[r_pcount[PNT_IDX_W-1:0]] <= r_corner[r_k];
        end
        r_pt_rd <= r_pt_mem[r_ptr[PNT_IDX_W-1:0]];
    end

    // Facet memory: one write, one registered read; the shift writes behind the read
    always_ff @(posedge i_clk) begin
        if (w_fc_we) begin
            r_fc_mem[w_fc_waddr] <= w_fc_wdata;
        end
        r_fc_rd <= r_fc_mem[r_ptr[FCT_IDX_W-1:0]];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pcount <= '0;
            r_fcount <= '0;
            r_ptr    <= '0;
            r_rv     <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rv   <= w_rd_issue;
            r_ridx <= r_ptr;
            if (w_rd_issue) begin
                r_ptr <= r_ptr + SCAN_W'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd     <= i_s_axis_tuser;
                        r_corner[0] <= i_s_axis_tdata[0 +: $bits(t_point)];
                        r_corner[1] <= i_s_axis_tdata[$bits(t_point) +: $bits(t_point)];
                        r_corner[2] <= i_s_axis_tdata[2*$bits(t_point) +: $bits(t_point)];
                        r_hit     <= '0;
                        r_idx[0]  <= '0;
                        r_idx[1]  <= '0;
                        r_idx[2]  <= '0;
                        r_report  <= 1'b0;
                        r_status  <= STS_OK;
                        r_ptr     <= '0;
                        r_found   <= 1'b0;
                        unique case (i_s_axis_tuser) inside
                            CMD_INSERT, CMD_REMOVE: r_state <= S_PSCAN;
                            CMD_CLEAR: begin
                                r_pcount <= '0;
                                r_fcount <= '0;
                                r_state  <= S_RESULT;
                            end
                            default: r_state <= S_RESULT;
                        endcase
                    end
                end
                S_PSCAN: begin
                    // Later matches overwrite earlier ones
                    if (r_rv) begin
                        if (w_match.first) begin
                            r_hit[0] <= 1'b1;
                            r_idx[0] <= r_ridx[PNT_IDX_W-1:0];
                        end
                        if (w_match.second) begin
                            r_hit[1] <= 1'b1;
                            r_idx[1] <= r_ridx[PNT_IDX_W-1:0];
                        end
                        if (w_match.third) begin
                            r_hit[2] <= 1'b1;
                            r_idx[2] <= r_ridx[PNT_IDX_W-1:0];
                        end
                    end
                    if (!w_rd_issue && !r_rv) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_cmd == CMD_INSERT) begin
                        if (w_full) begin
                            r_status <= STS_FULL;
                            r_state  <= S_RESULT;
                        end else begin
                            r_k     <= '0;
                            r_state <= S_APPEND;
                        end
                    end else if (!(&r_hit)) begin
                        r_status <= STS_NO_POINTS;
                        r_state  <= S_RESULT;
                    end else begin
                        r_ptr   <= '0;
                        r_state <= S_FSCAN;
                    end
                end
                S_APPEND: begin
                    // Unmatched corners take the next point indices in order
                    if (!r_hit[r_k]) begin
                        r_idx[r_k] <= r_pcount[PNT_IDX_W-1:0];
                        r_pcount   <= r_pcount + PNT_CNT_W'(1);
                    end
                    if (r_k == 2'd2) begin
                        r_state <= S_FAPPEND;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_FAPPEND: begin
                    r_fcount <= r_fcount + FCT_CNT_W'(1);
                    r_report <= 1'b1;
                    r_state  <= S_RESULT;
                end
                S_FSCAN: begin
                    // First matching facet; later ones move down one place
                    if (r_rv && !r_found && w_tri_match) begin
                        r_found <= 1'b1;
                    end
                    if (!w_rd_issue && !r_rv) begin
                        r_report <= 1'b1;
                        if (r_found) begin
                            r_fcount <= r_fcount - FCT_CNT_W'(1);
                            r_status <= STS_OK;
                        end else begin
                            r_status <= STS_NO_FACET;
                        end
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result word, held through the transfer
    assign o_m_axis_tdata = OUT_DATA_W'({
        OUT_CNT_W'(r_pcount),
        OUT_CNT_W'(r_fcount),
        r_report ? OUT_IDX_W'(r_idx[2]) : OUT_IDX_W'(0),
        r_report ? OUT_IDX_W'(r_idx[1]) : OUT_IDX_W'(0),
        r_report ? OUT_IDX_W'(r_idx[0]) : OUT_IDX_W'(0),
        r_status
    });

    // Checks
    `MVD_ASSERT_RST(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE && r_pcount == '0), "reset did not empty the tables")
    `MVD_ASSERT(a_pcount_max, r_pcount <= PNT_CNT_W'(MAX_POINTS), "point count over capacity")
    `MVD_ASSERT(a_fcount_max, r_fcount <= FCT_CNT_W'(MAX_FACETS), "facet count over capacity")
    `MVD_ASSERT(a_scan_bound, (r_state == S_PSCAN) |-> (r_ptr <= SCAN_W'(r_pcount)), "point scan ran past count")
    `MVD_ASSERT(a_shift_slot, (w_fc_we && r_state == S_FSCAN) |-> (r_ridx != '0), "facet shift wrote below index zero")
    `MVD_ASSERT(a_fappend_inc, (r_state == S_FAPPEND) |=> (r_fcount == $past(r_fcount) + FCT_CNT_W'(1)), "facet append did not count")

endmodule
